// ===== hw/rtl/ipv4af_pkg.sv =====
`timescale 1ns / 1ps

package ipv4af_pkg;

  localparam int TableEntries = 16;
  localparam int SlotIdxW     = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  localparam logic ReqWrite = 1'b0;
  localparam logic ReqCheck = 1'b1;

  localparam logic [1:0] KindUnused = 2'd0;
  localparam logic [1:0] KindSingle = 2'd1;
  localparam logic [1:0] KindRange  = 2'd2;

  localparam logic CfgFilterEnable = 1'b0;
  localparam logic CfgFilterMode   = 1'b1;

  localparam logic ModeDeny  = 1'b0;
  localparam logic ModeAllow = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] low;
    logic [31:0] high;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [SlotIdxW-1:0] addr;
    entry_t              entry;
  } wr_req_t;

endpackage

// ===== hw/rtl/ipv4_access_filter.sv =====
// IPv4 allow/deny filter over a table of TableEntries slots, each unused, a
// single address or an inclusive range. A write word stores one slot and its
// acknowledgement (reply_kind 0) is registered from the done state; a check
// word gets its verdict (reply_kind 1) after the scan has visited all slots,
// since the slot memory has one read port and the scan compares one slot per
// cycle, and the verdict is then registered from the done state. One word
// is in flight at a time; the next word is taken once the reply is registered.
// The table reads as all unused after reset. Registers: index 0 filter_enable
// (reset 0, 0 permits everything), index 1 filter_mode (reset 1, 0 deny,
// 1 allow); write them only while the block is idle.
`timescale 1ns / 1ps

module ipv4_access_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  entry_index_i,
  input  logic [1:0]  entry_kind_i,
  input  logic [31:0] range_low_i,
  input  logic [31:0] range_high_i,
  input  logic [31:0] lookup_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reply_kind_o,
  output logic        permitted_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  localparam logic [ipv4af_pkg::SlotIdxW-1:0] LastSlot =
    ipv4af_pkg::SlotIdxW'(ipv4af_pkg::TableEntries - 1);

  state_e                              state_q, state_d;
  logic [ipv4af_pkg::SlotIdxW-1:0]     cnt_q, cnt_d;
  logic                                any_q, any_d;
  logic                                kind_q, kind_d;
  logic [31:0]                         addr_q, addr_d;
  logic                                enable_q, mode_q;
  logic                                out_valid_q, out_valid_d;
  logic                                reply_kind_q, reply_kind_d;
  logic                                permitted_q, permitted_d;

  ipv4af_pkg::wr_req_t                 wr;
  logic [ipv4af_pkg::SlotIdxW-1:0]     rd_addr;
  ipv4af_pkg::entry_t                  rd_data;
  logic                                in_fire, slot_hit, verdict;

  ipv4af_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == StIdle);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = reply_kind_q;
  assign permitted_o  = permitted_q;

  always_comb begin
    wr.en          = in_fire && (req_type_i == ipv4af_pkg::ReqWrite) &&
                     (32'(entry_index_i) < ipv4af_pkg::TableEntries);
    wr.addr        = ipv4af_pkg::SlotIdxW'(entry_index_i);
    wr.entry.kind  = entry_kind_i;
    wr.entry.low   = range_low_i;
    wr.entry.high  = range_high_i;
  end

  assign rd_addr = (state_q == StScan) ? cnt_q + 1'b1 : '0;

  always_comb begin
    unique case (rd_data.kind)
      ipv4af_pkg::KindSingle: slot_hit = (addr_q == rd_data.low);
      ipv4af_pkg::KindRange:  slot_hit = (addr_q >= rd_data.low) && (addr_q <= rd_data.high);
      default:                slot_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (!enable_q) begin
      verdict = 1'b1;
    end else if (mode_q == ipv4af_pkg::ModeDeny) begin
      verdict = !any_q;
    end else begin
      verdict = any_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    any_d        = any_q;
    kind_d       = kind_q;
    addr_d       = addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    reply_kind_d = reply_kind_q;
    permitted_d  = permitted_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          kind_d = req_type_i;
          addr_d = lookup_address_i;
          cnt_d  = '0;
          any_d  = 1'b0;
          state_d = (req_type_i == ipv4af_pkg::ReqCheck) ? StScan : StDone;
        end
      end
      StScan: begin
        any_d = any_q | slot_hit;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          reply_kind_d = kind_q;
          permitted_d  = (kind_q == ipv4af_pkg::ReqCheck) ? verdict : 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      any_q       <= 1'b0;
      kind_q      <= ipv4af_pkg::ReqWrite;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      mode_q      <= ipv4af_pkg::ModeAllow;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      any_q       <= any_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          ipv4af_pkg::CfgFilterEnable: enable_q <= cfg_data_i;
          ipv4af_pkg::CfgFilterMode:   mode_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    reply_kind_q <= reply_kind_d;
    permitted_q  <= permitted_d;
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != StIdle)
    else $error("accepted word did not start work");

  a_check_scan_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && req_type_i == ipv4af_pkg::ReqCheck |=> state_q == StScan && cnt_q == '0)
    else $error("scan did not start at slot zero");

  a_reply_only_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StDone)
    else $error("reply raised outside the result state");

  a_write_ack_not_permitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && reply_kind_q == ipv4af_pkg::ReqWrite |-> !permitted_q)
    else $error("write acknowledgement carries a verdict");

  a_table_written_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> state_q == StIdle && !$past(state_q == StScan && cnt_q != LastSlot))
    else $error("table written during a scan");

endmodule

// ===== hw/rtl/ipv4af_table.sv =====
`timescale 1ns / 1ps

module ipv4af_table (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ipv4af_pkg::wr_req_t              wr_i,
  input  logic [ipv4af_pkg::SlotIdxW-1:0]  rd_addr_i,
  output ipv4af_pkg::entry_t               rd_data_o
);

  ipv4af_pkg::entry_t                        mem_q [ipv4af_pkg::TableEntries];
  logic [ipv4af_pkg::TableEntries-1:0]       valid_q;
  ipv4af_pkg::entry_t                        rd_q;
  logic                                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  // per-slot valid bits: a slot never written reads as unused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  always_comb begin
    rd_data_o      = rd_q;
    rd_data_o.kind = rd_vld_q ? rd_q.kind : ipv4af_pkg::KindUnused;
  end

endmodule

// ===== sim/ipv4_access_filter_test.sv =====
`timescale 1ns / 1ps

module ipv4_access_filter_test;

  localparam logic       ReplyAck     = 1'b0;
  localparam logic       ReplyVerdict = 1'b1;
  localparam logic [1:0] KindSpare    = 2'd3;
  localparam int         IdlePct      = 27;
  localparam int         RandomItems  = 1150;
  localparam int         Phases       = 8;
  localparam int         QuietPhase   = 5;
  localparam int         HotDepth     = 64;
  // per phase, bit p is phase p
  localparam logic [Phases-1:0] PhaseEnable = 8'b1110_1011;
  localparam logic [Phases-1:0] PhaseMode   = 8'b1011_0010;

  // Mirror of the filter table; queues {reply_kind, permitted} per accepted word.
  class verdict_board;
    logic [1:0]  tab_kind  [ipv4af_pkg::TableEntries];
    logic [31:0] tab_first [ipv4af_pkg::TableEntries];
    logic [31:0] tab_last  [ipv4af_pkg::TableEntries];
    logic        filter_on;
    logic        list_mode;
    logic [1:0]  due_replies [$];
    int          mismatches;

    function new();
      for (int i = 0; i < ipv4af_pkg::TableEntries; i++) begin
        tab_kind[i]  = ipv4af_pkg::KindUnused;
        tab_first[i] = '0;
        tab_last[i]  = '0;
      end
      filter_on  = 1'b0;
      list_mode  = ipv4af_pkg::ModeAllow;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic val);
      if (idx == ipv4af_pkg::CfgFilterEnable) filter_on = val;
      else list_mode = val;
    endfunction

    function logic verdict(logic [31:0] addr);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < ipv4af_pkg::TableEntries; i++) begin
        if (tab_kind[i] == ipv4af_pkg::KindSingle && addr == tab_first[i]) hit = 1'b1;
        if (tab_kind[i] == ipv4af_pkg::KindRange && addr >= tab_first[i] &&
            addr <= tab_last[i])
          hit = 1'b1;
      end
      if (!filter_on) return 1'b1;
      return (list_mode == ipv4af_pkg::ModeDeny) ? !hit : hit;
    endfunction

    function void note_request(logic req, logic [3:0] idx, logic [1:0] kind,
                               logic [31:0] lo, logic [31:0] hi, logic [31:0] addr);
      if (req == ipv4af_pkg::ReqWrite) begin
        if (idx < ipv4af_pkg::TableEntries) begin
          tab_kind[idx]  = kind;
          tab_first[idx] = lo;
          tab_last[idx]  = hi;
        end
        due_replies.push_back({ReplyAck, 1'b0});
      end else begin
        due_replies.push_back({ReplyVerdict, verdict(addr)});
      end
    endfunction

    function void flag(string what, logic [1:0] want, logic [1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected kind %b permitted %b, got kind %b permitted %b",
                 $realtime, what, want[1], want[0], got[1], got[0]);
    endfunction

    function void check_reply(logic kind, logic perm);
      logic [1:0] want;
      if (due_replies.size() == 0) begin
        flag("unexpected word", 2'bxx, {kind, perm});
        return;
      end
      want = due_replies.pop_front();
      if (kind !== want[1]) flag("reply_kind mismatch", want, {kind, perm});
      else if (perm !== want[0]) flag("permitted mismatch", want, {kind, perm});
    endfunction

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i      = 1'b0;
  logic        cfg_data_i       = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic        req_type_i       = 1'b0;
  logic [3:0]  entry_index_i    = '0;
  logic [1:0]  entry_kind_i     = '0;
  logic [31:0] range_low_i      = '0;
  logic [31:0] range_high_i     = '0;
  logic [31:0] lookup_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic        reply_kind_o;
  logic        permitted_o;

  bit           no_gaps = 1'b0;
  verdict_board board;
  logic [31:0]  hot_addrs [$];

  ipv4_access_filter i_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) out_ready_i <= no_gaps || ($urandom_range(99) >= IdlePct);

  // handshake values are stable from the falling edge to the accepting edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_reply(reply_kind_o, permitted_o);
  end

  task automatic send_request(logic req, logic [3:0] idx, logic [1:0] kind,
                              logic [31:0] lo, logic [31:0] hi, logic [31:0] addr);
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= req;
    entry_index_i    <= idx;
    entry_kind_i     <= kind;
    range_low_i      <= lo;
    range_high_i     <= hi;
    lookup_address_i <= addr;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    board.note_request(req, idx, kind, lo, hi, addr);
  endtask

  task automatic check_addr(logic [31:0] addr);
    send_request(ipv4af_pkg::ReqCheck, 4'($urandom_range(15)), 2'($urandom_range(3)),
                 $urandom, $urandom, addr);
  endtask

  task automatic await_replies();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic en, logic md);
    logic idx;
    logic val;
    await_replies();
    for (int r = 0; r < 2; r++) begin
      idx = (r == 0) ? ipv4af_pkg::CfgFilterEnable : ipv4af_pkg::CfgFilterMode;
      val = (r == 0) ? en : md;
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      do @(negedge clk_i); while (!cfg_ready_o);
      @(posedge clk_i);
      board.set_register(idx, val);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    logic        req;
    logic [3:0]  idx;
    logic [1:0]  kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] addr;
    logic [32:0] top;
    int          pick;
    req  = ($urandom_range(99) < 30) ? ipv4af_pkg::ReqWrite : ipv4af_pkg::ReqCheck;
    idx  = 4'($urandom_range(15));
    kind = 2'($urandom_range(3));
    lo   = $urandom;
    hi   = $urandom;
    addr = $urandom;
    if (req == ipv4af_pkg::ReqWrite) begin
      pick = $urandom_range(99);
      kind = (pick < 40) ? ipv4af_pkg::KindSingle : (pick < 80) ? ipv4af_pkg::KindRange :
             (pick < 90) ? ipv4af_pkg::KindUnused : KindSpare;
      if (hot_addrs.size() != 0 && $urandom_range(3) == 0)
        lo = hot_addrs[$urandom_range(hot_addrs.size() - 1)];
      pick = $urandom_range(99);
      if (pick < 70) begin
        top = {1'b0, lo} + $urandom_range(255);
        hi  = top[32] ? 32'hFFFF_FFFF : top[31:0];
      end else if (pick < 82) begin
        hi = lo - 32'd1 - $urandom_range(255);
      end else if (pick < 90) begin
        hi = lo;
      end else if (pick < 92) begin
        lo = 32'h0;
        hi = 32'hFFFF_FFFF;
      end
      hot_addrs.push_back(lo);
      hot_addrs.push_back(hi);
      hot_addrs.push_back(lo - 32'd1);
      hot_addrs.push_back(hi + 32'd1);
      while (hot_addrs.size() > HotDepth) void'(hot_addrs.pop_front());
    end else begin
      pick = $urandom_range(99);
      if (pick < 60 && hot_addrs.size() != 0)
        addr = hot_addrs[$urandom_range(hot_addrs.size() - 1)];
      else if (pick < 70)
        addr = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    end
    send_request(req, idx, kind, lo, hi, addr);
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // filter off after reset
    check_addr(32'h0);
    check_addr(32'hFFFF_FFFF);
    // empty table in both modes
    apply_setting(1'b1, ipv4af_pkg::ModeAllow);
    check_addr(32'h0A00_0001);
    apply_setting(1'b1, ipv4af_pkg::ModeDeny);
    check_addr(32'h0A00_0001);

    send_request(ipv4af_pkg::ReqWrite, 4'd0, ipv4af_pkg::KindSingle, 32'h0A00_0001,
                 32'h0B00_0000, 32'h0);
    send_request(ipv4af_pkg::ReqWrite, 4'd15, ipv4af_pkg::KindRange, 32'hC0A8_0000,
                 32'hC0A8_00FF, 32'h0);
    send_request(ipv4af_pkg::ReqWrite, 4'd3, ipv4af_pkg::KindRange, 32'h0000_0020,
                 32'h0000_0010, 32'h0);
    send_request(ipv4af_pkg::ReqWrite, 4'd7, KindSpare, 32'h5555_5555, 32'h5555_5555, 32'h0);
    send_request(ipv4af_pkg::ReqWrite, 4'd8, ipv4af_pkg::KindRange, 32'h0, 32'h0,
                 32'hFFFF_FFFF);
    send_request(ipv4af_pkg::ReqWrite, 4'd9, ipv4af_pkg::KindSingle, 32'hFFFF_FFFF, 32'h0,
                 32'h0);

    check_addr(32'h0A00_0001);
    check_addr(32'h0B00_0000);
    check_addr(32'hC0A8_0000);
    check_addr(32'hC0A8_00FF);
    check_addr(32'hC0A8_0100);
    check_addr(32'h0000_0018);
    check_addr(32'h5555_5555);
    check_addr(32'h0);
    check_addr(32'hFFFF_FFFF);

    apply_setting(1'b1, ipv4af_pkg::ModeAllow);
    check_addr(32'h0A00_0001);
    check_addr(32'hC0A8_0080);
    check_addr(32'h0000_0018);
    check_addr(32'h5555_5555);
    send_request(ipv4af_pkg::ReqWrite, 4'd0, ipv4af_pkg::KindUnused, 32'h0A00_0001,
                 32'h0A00_0001, 32'h0);
    check_addr(32'h0A00_0001);

    for (int p = 0; p < Phases; p++) begin
      apply_setting(PhaseEnable[p], PhaseMode[p]);
      no_gaps = (p == QuietPhase);
      for (int n = 0; n < RandomItems / Phases; n++) begin
        if (p == 2 && n == 70) await_replies();
        random_item();
      end
    end
    no_gaps = 1'b0;

    await_replies();
    repeat (30) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("ipv4_access_filter_test OK");
    end else begin
      $display("ipv4_access_filter_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ipv4_access_filter_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ipv4af_pkg.sv
hw/rtl/ipv4af_table.sv
hw/rtl/ipv4_access_filter.sv
sim/ipv4_access_filter_test.sv
